### rtl/core/wfpa_pkg.sv
package wfpa_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ID_W        = 8;
  localparam int SIZE_W      = 16;
  localparam int STAT_W      = 3;

  localparam logic [SIZE_W-1:0] TOTAL_SIZE_RESET = 16'd4096;
  localparam logic [ID_W-1:0]   FREE_ID          = 8'd0;

  localparam logic ACT_STORE  = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOFIT    = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic commit;
  } wfpa_cmd_t;

  typedef struct packed {
    logic scan_last;
  } wfpa_sts_t;

endpackage

### rtl/core/wfpa_ctrl.sv
module wfpa_ctrl
  import wfpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output wfpa_cmd_t cmd,
  input  wfpa_sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> slot_free)
    else $error("result overwritten while a beat is still pending");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit did not raise out_tvalid");

endmodule

### rtl/core/wfpa_dp.sv
module wfpa_dp
  import wfpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  input  logic [0:0]        in_tuser,
  input  logic [23:0]       in_tdata,
  input  wfpa_cmd_t         cmd,
  output wfpa_sts_t         sts,
  output logic [23:0]       out_tdata
);

  logic [ID_W-1:0]   entry_id_r    [MAX_ENTRIES];
  logic [SIZE_W-1:0] entry_start_r [MAX_ENTRIES];
  logic [SIZE_W-1:0] entry_size_r  [MAX_ENTRIES];
  logic              entry_free_r  [MAX_ENTRIES];
  logic [CNT_W-1:0]  count_r;
  logic [SIZE_W-1:0] total_r;

  logic              act_r;
  logic [ID_W-1:0]   id_r;
  logic [SIZE_W-1:0] req_r;
  logic [IDX_W-1:0]  scan_idx_r;
  logic              found_r;
  logic [IDX_W-1:0]  hit_r;
  logic [IDX_W-1:0]  best_r;
  logic [SIZE_W-1:0] best_size_r;
  logic [SIZE_W-1:0] best_start_r;

  status_t           status_r;
  logic [SIZE_W-1:0] start_r;

  logic [ID_W-1:0]   cur_id;
  logic [SIZE_W-1:0] cur_start;
  logic [SIZE_W-1:0] cur_size;
  logic              cur_free;
  logic              better;
  logic [SIZE_W-1:0] rest;
  logic              grow;
  logic [IDX_W-1:0]  best_p1;
  status_t           status_c;
  logic [SIZE_W-1:0] start_c;
  logic              store_ok;
  logic              del_ok;

  assign cur_id    = entry_id_r[scan_idx_r];
  assign cur_start = entry_start_r[scan_idx_r];
  assign cur_size  = entry_size_r[scan_idx_r];
  assign cur_free  = entry_free_r[scan_idx_r];
  assign better    = cur_free && (req_r <= cur_size) && (cur_size > best_size_r);

  assign sts.scan_last = (CNT_W'(scan_idx_r) + CNT_W'(1)) == count_r;

  assign rest    = best_size_r - req_r;
  assign grow    = (rest != '0);
  assign best_p1 = best_r + IDX_W'(1);

  always_comb begin
    status_c = ST_OK;
    start_c  = '0;
    store_ok = 1'b0;
    del_ok   = 1'b0;
    if (act_r == ACT_STORE) begin
      if (req_r > total_r) begin
        status_c = ST_NOFIT;
      end else if (found_r) begin
        status_c = ST_DUP;
      end else if (best_size_r == '0) begin
        status_c = ST_NOFIT;
      end else if (grow && (count_r == CNT_W'(MAX_ENTRIES))) begin
        status_c = ST_FULL;
      end else begin
        store_ok = 1'b1;
        start_c  = best_start_r;
      end
    end else if (!found_r) begin
      status_c = ST_NOTFOUND;
    end else begin
      del_ok = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r       <= in_tuser[0];
      id_r        <= in_tdata[7:0];
      req_r       <= in_tdata[23:8];
      scan_idx_r  <= '0;
      found_r     <= 1'b0;
      hit_r       <= '0;
      best_r      <= '0;
      best_size_r <= '0;
      best_start_r <= '0;
    end else if (cmd.scan) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
      if (cur_id == id_r) begin
        found_r <= 1'b1;
        hit_r   <= scan_idx_r;
      end
      if (better) begin
        best_r       <= scan_idx_r;
        best_size_r  <= cur_size;
        best_start_r <= cur_start;
      end
    end
    if (cmd.commit) begin
      status_r <= status_c;
      start_r  <= start_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r          <= TOTAL_SIZE_RESET;
      count_r          <= CNT_W'(1);
      entry_id_r[0]    <= FREE_ID;
      entry_start_r[0] <= '0;
      entry_size_r[0]  <= TOTAL_SIZE_RESET;
      entry_free_r[0]  <= 1'b1;
    end else if (cfg_we) begin
      total_r          <= cfg_wdata;
      count_r          <= CNT_W'(1);
      entry_id_r[0]    <= FREE_ID;
      entry_start_r[0] <= '0;
      entry_size_r[0]  <= cfg_wdata;
      entry_free_r[0]  <= 1'b1;
    end else if (cmd.commit && del_ok) begin
      entry_id_r[hit_r]   <= FREE_ID;
      entry_free_r[hit_r] <= 1'b1;
    end else if (cmd.commit && store_ok) begin
      if (grow) begin
        // open a slot after best: entries best+1..count-1 move up by one
        for (int i = 1; i < MAX_ENTRIES; i++) begin
          if ((IDX_W'(i) > best_p1) && (CNT_W'(i) <= count_r)) begin
            entry_id_r[i]    <= entry_id_r[i-1];
            entry_start_r[i] <= entry_start_r[i-1];
            entry_size_r[i]  <= entry_size_r[i-1];
            entry_free_r[i]  <= entry_free_r[i-1];
          end
        end
        count_r                <= count_r + CNT_W'(1);
        entry_id_r[best_r]     <= FREE_ID;
        entry_start_r[best_r]  <= best_start_r + req_r;
        entry_size_r[best_r]   <= rest;
        entry_free_r[best_r]   <= 1'b1;
        entry_id_r[best_p1]    <= id_r;
        entry_start_r[best_p1] <= best_start_r;
        entry_size_r[best_p1]  <= req_r;
        entry_free_r[best_p1]  <= 1'b0;
      end else begin
        entry_id_r[best_r]    <= id_r;
        entry_start_r[best_r] <= best_start_r;
        entry_size_r[best_r]  <= req_r;
        entry_free_r[best_r]  <= 1'b0;
      end
    end
  end

  assign out_tdata = {5'd0, start_r, status_r};

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= CNT_W'(MAX_ENTRIES)))
    else $error("entry count out of range");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> (CNT_W'(scan_idx_r) < count_r))
    else $error("scan past last entry");

  a_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && store_ok && grow && !cfg_we) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("split did not add an entry");

endmodule

### rtl/core/worst_fit_partition_allocator.sv
// Channel  Dir  tdata                                    tuser
// in_      in   [7:0] part_id, [23:8] request_size        [0] action
// out_     out  [2:0] status, [18:3] start_offset, pad    -
// cfg_     in   cfg_wdata: total_size, written on cfg_we  -
//
// A beat is accepted, its table scan visits each entry (count = table entries, 1..16),
// and a commit does the insert/update; in_tready stays low until that commit.
// Sync active-low reset: one free entry of 4096 bytes; a total_size write
// reinitializes the table the same way.
// The result register holds a beat until out_tready; commit waits for it.
module worst_fit_partition_allocator
  import wfpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,   // total_size
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,    // part_id, request_size
  input  logic [0:0]        in_tuser,    // action
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata    // status, start_offset, zero pad
);

  wfpa_cmd_t cmd;
  wfpa_sts_t sts;

  wfpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  wfpa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule
